/* src/amr_rtp_pkg.sv */
`timescale 1ns / 1ps

package amr_rtp_pkg;

    // Default number of table-of-contents entries kept per payload.
    localparam int unsigned TOC_DEPTH_DEF = 16;

    // Most results a single payload byte can cause.
    localparam int unsigned MAX_RES = 3;

    // Highest frame type that carries speech data.
    localparam logic [3:0] SPEECH_FT_MAX = 4'd8;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [3:0] frame_number;
        logic       frame_end;
        logic       payload_end;
        logic [3:0] request_mode;
        logic       bad_entry;
    } res_t;

    // Speech frame length in bytes for each valid frame type.
    function automatic logic [4:0] frame_bytes(input logic [3:0] ft);
        logic [4:0] len;
        unique case (ft)
            4'd0:    len = 5'd12;
            4'd1:    len = 5'd13;
            4'd2:    len = 5'd15;
            4'd3:    len = 5'd17;
            4'd4:    len = 5'd19;
            4'd5:    len = 5'd20;
            4'd6:    len = 5'd26;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd5;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* src/amr_rtp_if.sv */
`timescale 1ns / 1ps

// Payload byte channel.
interface amr_rtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_last;

    modport source (output valid, output payload_byte, output payload_last, input ready);
    modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

// Result channel.
interface amr_rtp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] frame_number;
    logic       frame_end;
    logic       payload_end;
    logic [3:0] request_mode;
    logic       bad_entry;

    modport source (
        output valid, output kind, output out_byte, output frame_number,
        output frame_end, output payload_end, output request_mode,
        output bad_entry, input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input frame_number,
        input frame_end, input payload_end, input request_mode,
        input bad_entry, output ready
    );
endinterface

// Configuration write channel.
interface amr_rtp_cfg_if;
    logic valid;
    logic ready;
    logic octet_aligned_mode;

    modport source (output valid, output octet_aligned_mode, input ready);
    modport sink   (input valid, input octet_aligned_mode, output ready);
endinterface

/* src/amr_rtp_payload_depacketizer.sv */
`timescale 1ns / 1ps

// AMR RTP payload depacketizer.
// Payload bytes enter on the payload channel, most significant bit first, with
// payload_last on the final byte of each payload. For every table-of-contents
// entry the block sends a header byte on the result channel, then that frame's
// data bytes realigned from the current bit position. The cfg channel writes
// octet_aligned_mode and is always ready; write it only while the block is idle.
// An accepted item waits in the input register while the step logic works out
// all of its results, which then enter a four-entry result queue and are
// offered from its head. One item is taken per cycle while the queue drains,
// so the output port, at one result per cycle, sets the pace. A byte that
// completes two table entries holds the next item back, as the entry table has
// a single write port. When the receiver stalls, the queue fills and
// payload.ready falls until room for three more results is free. Reset clears
// the parser state but for the bit buffer and the first entry, the mode
// register and the queue; the entry table is only read after being written
// within the same payload.
module amr_rtp_payload_depacketizer import amr_rtp_pkg::*; #(
    parameter int unsigned TOC_DEPTH = TOC_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    amr_rtp_cfg_if.sink   cfg,
    amr_rtp_in_if.sink    payload,
    amr_rtp_out_if.source result
);

    localparam int unsigned AW = (TOC_DEPTH > 1) ? $clog2(TOC_DEPTH) : 1;

    logic          octet_reg;
    logic          item_valid_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    logic          accept;
    logic          fire;
    logic          busy;
    logic          room;
    logic          pop;
    logic          head_valid;
    res_t          head;
    logic [1:0]    res_n;
    logic [1:0]    push_n;
    res_t          res [MAX_RES];

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [5:0]    ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [5:0]    ram_rd_data;

    // The mode register takes a write whenever one is offered.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            octet_reg <= cfg.octet_aligned_mode;
        end
    end

    // The held item is processed once the queue has room for its results and
    // no deferred table write is outstanding.
    assign fire          = item_valid_reg & ~busy & room;
    assign payload.ready = ~item_valid_reg | fire;
    assign accept        = payload.valid & payload.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= payload.payload_byte;
            last_reg <= payload.payload_last;
        end
    end

    amr_rtp_core #(
        .TOC_DEPTH (TOC_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .octet       (octet_reg),
        .in_byte     (byte_reg),
        .in_last     (last_reg),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .busy        (busy),
        .res_n       (res_n),
        .res         (res)
    );

    // Table of contents entries: F, FT and Q of each frame.
    amr_rtp_ram #(
        .WIDTH (6),
        .DEPTH (TOC_DEPTH)
    ) u_toc_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign push_n = fire ? res_n : 2'd0;
    assign pop    = head_valid & result.ready;

    amr_rtp_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_data  (res),
        .pop        (pop),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    // The queue head drives the result channel directly from registers.
    assign result.valid        = head_valid;
    assign result.kind         = head.kind;
    assign result.out_byte     = head.out_byte;
    assign result.frame_number = head.frame_number;
    assign result.frame_end    = head.frame_end;
    assign result.payload_end  = head.payload_end;
    assign result.request_mode = head.request_mode;
    assign result.bad_entry    = head.bad_entry;

endmodule

/* src/amr_rtp_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module amr_rtp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

/* src/amr_rtp_core.sv */
`timescale 1ns / 1ps

// Parser state and the single-pass step logic for one payload byte.
module amr_rtp_core import amr_rtp_pkg::*; #(
    parameter int unsigned TOC_DEPTH = TOC_DEPTH_DEF,
    localparam int unsigned AW = (TOC_DEPTH > 1) ? $clog2(TOC_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          octet,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic [5:0]    ram_rd_data,
    output logic          ram_wr_en,
    output logic [AW-1:0] ram_wr_addr,
    output logic [5:0]    ram_wr_data,
    output logic [AW-1:0] ram_rd_addr,
    output logic          busy,
    output logic [1:0]    res_n,
    output res_t          res [MAX_RES]
);

    localparam int unsigned CW = $clog2(TOC_DEPTH + 1);
    localparam int unsigned ITER = 3;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_TOC    = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [15:0]     bits_reg, bits_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [CW-1:0]   ecount_reg, ecount_next;
    logic [CW-1:0]   cframe_reg, cframe_next;
    logic [4:0]      remain_reg, remain_next;
    logic [3:0]      req_reg, req_next;
    logic            err_reg, err_next;
    logic [5:0]      first_reg, first_next;
    logic            pend_valid_reg;
    logic [AW-1:0]   pend_addr_reg;
    logic [5:0]      pend_data_reg;

    logic            wr0_en, wr1_en;
    logic [AW-1:0]   wr0_addr, wr1_addr;
    logic [5:0]      wr0_data, wr1_data;
    logic [CW:0]     cf_inc;

    function automatic res_t mk_res(
        input kind_t      k,
        input logic [7:0] b,
        input logic [3:0] fn,
        input logic       fend,
        input logic [3:0] rq,
        input logic       er
    );
        res_t r;
        r.kind         = k;
        r.out_byte     = b;
        r.frame_number = fn;
        r.frame_end    = fend;
        r.payload_end  = 1'b0;
        r.request_mode = rq;
        r.bad_entry    = er;
        return r;
    endfunction

    always_comb
    begin
        phase_t      ph;
        logic [15:0] bb;
        logic [15:0] padw;
        logic [3:0]  bc;
        logic [3:0]  need;
        logic [3:0]  sh;
        logic [7:0]  fld;
        logic [5:0]  ent;
        logic [5:0]  e;
        logic [CW-1:0] ec;
        logic [CW-1:0] cf;
        logic [4:0]  rem;
        logic [3:0]  rq;
        logic        er;
        logic [5:0]  fe;
        logic [1:0]  n;
        logic        stop;
        logic        start;
        logic        from_list;

        ph = phase_reg;
        bb = bits_reg;
        bc = cnt_reg;
        ec = ecount_reg;
        cf = cframe_reg;
        rem = remain_reg;
        rq = req_reg;
        er = err_reg;
        fe = first_reg;
        n = 2'd0;
        stop = 1'b0;
        need = 4'd0;
        sh = 4'd0;
        fld = 8'd0;
        ent = 6'd0;
        e = 6'd0;
        padw = 16'd0;
        wr0_en = 1'b0;
        wr0_addr = '0;
        wr0_data = '0;
        wr1_en = 1'b0;
        wr1_addr = '0;
        wr1_data = '0;
        for (int j = 0; j < MAX_RES; j++)
        begin
            res[j] = '0;
        end

        if (ph != PH_DONE)
        begin
            bb = {bb[7:0], in_byte};
            bc = bc + 4'd8;
        end

        for (int i = 0; i < ITER; i++)
        begin
            start = 1'b0;
            from_list = 1'b0;
            if (!stop)
            begin
                unique case (ph)
                    PH_HEADER:
                    begin
                        need = octet ? 4'd8 : 4'd4;
                        if (bc < need)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            sh = bc - need;
                            fld = 8'(bb >> sh);
                            rq = octet ? fld[7:4] : fld[3:0];
                            bc = sh;
                            ph = PH_TOC;
                        end
                    end
                    PH_TOC:
                    begin
                        need = octet ? 4'd8 : 4'd6;
                        if (bc < need)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            sh = bc - need;
                            fld = 8'(bb >> sh);
                            ent = octet ? fld[7:2] : fld[5:0];
                            bc = sh;
                            if (ent[4:1] > SPEECH_FT_MAX)
                            begin
                                er = 1'b1;
                                start = 1'b1;
                            end
                            else if (ec < CW'(TOC_DEPTH))
                            begin
                                if (!wr0_en)
                                begin
                                    wr0_en = 1'b1;
                                    wr0_addr = AW'(ec);
                                    wr0_data = ent;
                                end
                                else
                                begin
                                    wr1_en = 1'b1;
                                    wr1_addr = AW'(ec);
                                    wr1_data = ent;
                                end
                                if (ec == '0)
                                begin
                                    fe = ent;
                                end
                                ec = ec + CW'(1);
                                if (!ent[5])
                                begin
                                    start = 1'b1;
                                end
                                else if (ec == CW'(TOC_DEPTH))
                                begin
                                    er = 1'b1;
                                    start = 1'b1;
                                end
                            end
                            else
                            begin
                                er = 1'b1;
                                start = 1'b1;
                            end
                            if (start)
                            begin
                                cf = '0;
                                from_list = 1'b1;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (bc < 4'd8)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            sh = bc - 4'd8;
                            fld = 8'(bb >> sh);
                            bc = sh;
                            if (rem != 5'd0)
                            begin
                                rem = rem - 5'd1;
                            end
                            if (rem == 5'd0)
                            begin
                                if (n < 2'd3)
                                begin
                                    res[n] = mk_res(KIND_DATA, fld, 4'(cf), 1'b1, rq, er);
                                    n = n + 2'd1;
                                end
                                cf = cf + CW'(1);
                                start = 1'b1;
                            end
                            else if (n < 2'd3)
                            begin
                                res[n] = mk_res(KIND_DATA, fld, 4'(cf), 1'b0, rq, er);
                                n = n + 2'd1;
                            end
                        end
                    end
                    default:
                    begin
                        stop = 1'b1;
                    end
                endcase

                // Open the next frame, or finish when the list is used up.
                if (start)
                begin
                    if (cf >= ec)
                    begin
                        ph = PH_DONE;
                        bc = 4'd0;
                    end
                    else
                    begin
                        e = from_list ? fe : ram_rd_data;
                        rem = frame_bytes(e[4:1]);
                        ph = PH_DATA;
                        if (n < 2'd3)
                        begin
                            res[n] = mk_res(KIND_HEADER, {e[5], e[4:1], e[0], 2'b00},
                                            4'(cf), 1'b0, rq, er);
                            n = n + 2'd1;
                        end
                    end
                end
            end
        end

        if (in_last)
        begin
            // A partial last byte of a frame is padded with zeros.
            if (ph == PH_DATA && bc != 4'd0)
            begin
                padw = bb << (4'd8 - bc);
                if (n < 2'd3)
                begin
                    res[n] = mk_res(KIND_DATA, padw[7:0], 4'(cf), 1'b1, rq, er);
                    n = n + 2'd1;
                end
                bc = 4'd0;
            end
            if (n == 2'd0)
            begin
                res[0] = mk_res(KIND_STATUS, 8'd0, 4'(cf), 1'b0, rq, er);
                n = 2'd1;
            end
            res[n - 2'd1].payload_end = 1'b1;
            ph = PH_HEADER;
            bb = 16'd0;
            bc = 4'd0;
            ec = '0;
            cf = '0;
            rem = 5'd0;
            rq = 4'd0;
            er = 1'b0;
        end

        phase_next = ph;
        bits_next = bb;
        cnt_next = bc;
        ecount_next = ec;
        cframe_next = cf;
        remain_next = rem;
        req_next = rq;
        err_next = er;
        first_next = fe;
        res_n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg <= 4'd0;
            ecount_reg <= '0;
            cframe_reg <= '0;
            remain_reg <= 5'd0;
            req_reg <= 4'd0;
            err_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                cnt_reg <= cnt_next;
                ecount_reg <= ecount_next;
                cframe_reg <= cframe_next;
                remain_reg <= remain_next;
                req_reg <= req_next;
                err_reg <= err_next;
            end
            pend_valid_reg <= fire & wr1_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            bits_reg <= bits_next;
            first_reg <= first_next;
        end
        if (fire && wr1_en)
        begin
            pend_addr_reg <= wr1_addr;
            pend_data_reg <= wr1_data;
        end
    end

    // A second entry from the same byte is held in a register and written in the following cycle.
    assign ram_wr_en   = pend_valid_reg | (fire & wr0_en);
    assign ram_wr_addr = pend_valid_reg ? pend_addr_reg : wr0_addr;
    assign ram_wr_data = pend_valid_reg ? pend_data_reg : wr0_data;
    assign busy        = pend_valid_reg;

    // Keep the entry of the following frame read ahead.
    assign cf_inc      = {1'b0, cframe_reg} + (CW + 1)'(1);
    assign ram_rd_addr = (cf_inc < (CW + 1)'(TOC_DEPTH)) ? AW'(cf_inc) : '0;

endmodule

/* src/amr_rtp_res_fifo.sv */
`timescale 1ns / 1ps

// Result queue: takes up to three results a cycle, gives one a cycle.
module amr_rtp_res_fifo import amr_rtp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push_data [MAX_RES],
    input  logic       pop,
    output logic       room,
    output logic       head_valid,
    output res_t       head
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    res_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] after_pop;

    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CNTW'(push_n) - CNTW'(pop);
    assign after_pop   = count_reg - CNTW'(pop);
    assign room        = after_pop <= CNTW'(DEPTH - MAX_RES);
    assign head_valid  = count_reg != '0;
    assign head        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (i < int'(push_n))
            begin
                mem_reg[wr_ptr_reg + PW'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* bench/amr_depack_compare.sv */
`timescale 1ns / 1ps

// Watches the three channels of the depacketizer, works out the results that each
// accepted payload byte should cause and compares them, in order, with what the
// block sends on its result channel.
module amr_depack_compare import amr_rtp_pkg::*; #(
    parameter int unsigned TOC_DEPTH = TOC_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    amr_rtp_cfg_if      cfg_ch,
    amr_rtp_in_if       byte_ch,
    amr_rtp_out_if      res_ch,
    output int unsigned fail_count,
    output int unsigned checked,
    output int unsigned pending
);

    typedef enum logic [1:0] {
        PS_HEADER,
        PS_TOC,
        PS_DATA,
        PS_DONE
    } parse_st_t;

    localparam logic [4:0] FRAME_LEN [0:8] = '{
        5'd12, 5'd13, 5'd15, 5'd17, 5'd19, 5'd20, 5'd26, 5'd31, 5'd5
    };

    logic        octet_mode;
    parse_st_t   parse_st;
    logic [15:0] bits_held;
    int unsigned bits_avail;
    logic [5:0]  toc_entries [TOC_DEPTH];
    int unsigned toc_count;
    int unsigned frame_idx;
    int unsigned data_left;
    logic [3:0]  cmr_value;
    logic        err_flag;

    res_t        step_res [MAX_RES];
    int unsigned n_res;
    res_t        frames_q [$];

    task automatic clear_payload();
        parse_st   = PS_HEADER;
        bits_held  = '0;
        bits_avail = 0;
        for (int i = 0; i < TOC_DEPTH; i++)
        begin
            toc_entries[i] = '0;
        end
        toc_count  = 0;
        frame_idx  = 0;
        data_left  = 0;
        cmr_value  = '0;
        err_flag   = 1'b0;
    endtask

    // Takes the n oldest bits held, most significant first.
    function automatic logic [7:0] pull_bits(input int unsigned n);
        logic [15:0] v;
        if (n == 0 || n > bits_avail) return 8'h00;
        v = (bits_held >> (bits_avail - n)) & ((16'h1 << n) - 16'h1);
        bits_avail -= n;
        bits_held &= (16'h1 << bits_avail) - 16'h1;
        return v[7:0];
    endfunction

    task automatic add_result(input kind_t k, input logic [7:0] b, input logic fe);
        res_t r;
        if (n_res < MAX_RES)
        begin
            r.kind         = k;
            r.out_byte     = b;
            r.frame_number = frame_idx[3:0];
            r.frame_end    = fe;
            r.payload_end  = 1'b0;
            r.request_mode = cmr_value;
            r.bad_entry    = err_flag;
            step_res[n_res] = r;
            n_res++;
        end
    endtask

    // Moves on to the frame at frame_idx, or finishes when the list is used up.
    task automatic open_frame();
        logic [5:0] e;
        if (frame_idx >= toc_count || frame_idx >= TOC_DEPTH)
        begin
            parse_st   = PS_DONE;
            bits_held  = '0;
            bits_avail = 0;
        end
        else
        begin
            e = toc_entries[frame_idx];
            data_left = (e[4:1] <= SPEECH_FT_MAX) ? FRAME_LEN[e[4:1]] : 0;
            parse_st = PS_DATA;
            add_result(KIND_HEADER, {e[5], e[4:1], e[0], 2'b00}, 1'b0);
        end
    endtask

    task automatic step_byte(input logic [7:0] b, input logic last);
        logic [7:0]  v;
        logic        f;
        logic [3:0]  ft;
        logic        end_list;
        logic        busy;
        int unsigned need;
        int unsigned k;
        n_res = 0;
        if (parse_st != PS_DONE)
        begin
            bits_held  = {bits_held[7:0], b};
            bits_avail += 8;
        end
        busy = 1'b1;
        while (busy)
        begin
            case (parse_st)
                PS_HEADER:
                begin
                    need = octet_mode ? 8 : 4;
                    if (bits_avail < need)
                    begin
                        busy = 1'b0;
                    end
                    else
                    begin
                        v = pull_bits(need);
                        cmr_value = octet_mode ? v[7:4] : v[3:0];
                        parse_st = PS_TOC;
                    end
                end
                PS_TOC:
                begin
                    need = octet_mode ? 8 : 6;
                    if (bits_avail < need)
                    begin
                        busy = 1'b0;
                    end
                    else
                    begin
                        v = pull_bits(need);
                        if (octet_mode) v = v >> 2;
                        f  = v[5];
                        ft = v[4:1];
                        end_list = 1'b0;
                        if (ft > SPEECH_FT_MAX)
                        begin
                            err_flag = 1'b1;
                            end_list = 1'b1;
                        end
                        else if (toc_count < TOC_DEPTH)
                        begin
                            toc_entries[toc_count] = v[5:0];
                            toc_count++;
                            if (!f)
                            begin
                                end_list = 1'b1;
                            end
                            else if (toc_count >= TOC_DEPTH)
                            begin
                                err_flag = 1'b1;
                                end_list = 1'b1;
                            end
                        end
                        else
                        begin
                            err_flag = 1'b1;
                            end_list = 1'b1;
                        end
                        if (end_list)
                        begin
                            frame_idx = 0;
                            open_frame();
                        end
                    end
                end
                PS_DATA:
                begin
                    if (bits_avail < 8)
                    begin
                        busy = 1'b0;
                    end
                    else
                    begin
                        v = pull_bits(8);
                        if (data_left > 0) data_left--;
                        if (data_left == 0)
                        begin
                            add_result(KIND_DATA, v, 1'b1);
                            frame_idx++;
                            open_frame();
                        end
                        else
                        begin
                            add_result(KIND_DATA, v, 1'b0);
                        end
                    end
                end
                default: busy = 1'b0;
            endcase
        end
        if (last)
        begin
            // A frame cut short keeps its leftover bits, padded with zeros.
            if (parse_st == PS_DATA && bits_avail > 0 && bits_avail < 8)
            begin
                k = bits_avail;
                v = pull_bits(k) << (8 - k);
                add_result(KIND_DATA, v, 1'b1);
            end
            if (n_res == 0) add_result(KIND_STATUS, 8'h00, 1'b0);
            step_res[n_res - 1].payload_end = 1'b1;
            clear_payload();
        end
        for (int i = 0; i < n_res; i++)
        begin
            frames_q.push_back(step_res[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            octet_mode = 1'b0;
            clear_payload();
            frames_q.delete();
            fail_count = 0;
            checked    = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready) octet_mode = cfg_ch.octet_aligned_mode;
            if (byte_ch.valid && byte_ch.ready)
            begin
                step_byte(byte_ch.payload_byte, byte_ch.payload_last);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (frames_q.size() == 0)
                begin
                    $error("result with no expectation waiting: kind %0d, byte %0h",
                           res_ch.kind, res_ch.out_byte);
                    fail_count++;
                end
                else
                begin
                    want = frames_q.pop_front();
                    check_field("kind", 8'(want.kind), 8'(res_ch.kind));
                    check_field("out_byte", want.out_byte, res_ch.out_byte);
                    check_field("frame_number", 8'(want.frame_number),
                                8'(res_ch.frame_number));
                    check_field("frame_end", 8'(want.frame_end), 8'(res_ch.frame_end));
                    check_field("payload_end", 8'(want.payload_end),
                                8'(res_ch.payload_end));
                    check_field("request_mode", 8'(want.request_mode),
                                8'(res_ch.request_mode));
                    check_field("bad_entry", 8'(want.bad_entry), 8'(res_ch.bad_entry));
                    checked++;
                end
            end
            pending <= frames_q.size();
        end
    end

endmodule

/* bench/tb_amr_rtp_payload_depacketizer.sv */
`timescale 1ns / 1ps

// Top of the depacketizer bench. It makes the clock and the reset, builds RTP
// payloads bit by bit and feeds them to the block one item at a time, holds the
// result channel back on a stall pattern of its own, and gives the verdict. All
// prediction and comparison happens in the compare module beside the block.
module tb_amr_rtp_payload_depacketizer import amr_rtp_pkg::*; ();

    // The limit leaves wide slack over the slowest correct run: under two hundred
    // items, each causing up to three results that may each wait on the receiver,
    // plus the sender's gaps.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // The drain wait gives the block ample slack to fall quiet before a mode write
    // or the verdict.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 60;
    localparam int unsigned PHASE_ITEMS  = 30;

    // Speech frame lengths in bytes, used only to build well-formed payloads.
    localparam logic [4:0] SPEECH_LEN [0:8] = '{
        5'd12, 5'd13, 5'd15, 5'd17, 5'd19, 5'd20, 5'd26, 5'd31, 5'd5
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    amr_rtp_cfg_if cfg_ch ();
    amr_rtp_in_if  byte_ch ();
    amr_rtp_out_if res_ch ();

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned pending;

    amr_rtp_payload_depacketizer #(
        .TOC_DEPTH (TOC_DEPTH_DEF)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .payload (byte_ch),
        .result  (res_ch)
    );

    amr_depack_compare #(
        .TOC_DEPTH (TOC_DEPTH_DEF)
    ) i_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_ch     (cfg_ch),
        .byte_ch    (byte_ch),
        .res_ch     (res_ch),
        .fail_count (mismatches),
        .checked    (results_seen),
        .pending    (pending)
    );

    // Watchdog: a run that hangs is a failed run.
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_amr_rtp_payload_depacketizer failed");
            $finish;
        end
    end

    // The receiver changes its manner every so often: free flow with only rare
    // drops, a random drop on about one cycle in four, or long stalls
    // alternating with short windows of readiness.
    logic        take_ready  = 1'b0;
    int unsigned ready_hold  = 0;
    int unsigned stall_style = 0;
    int unsigned style_left  = 0;

    assign res_ch.ready = take_ready;

    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style <= $urandom_range(0, 2);
            style_left  <= $urandom_range(20, 120);
        end
        else
        begin
            style_left <= style_left - 1;
        end
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            case (stall_style)
                0:
                begin
                    take_ready <= ($urandom_range(0, 15) != 0);
                    ready_hold <= $urandom_range(0, 30);
                end
                1:
                begin
                    take_ready <= ($urandom_range(0, 3) != 0);
                    ready_hold <= 0;
                end
                default:
                begin
                    take_ready <= ~take_ready;
                    ready_hold <= take_ready ? $urandom_range(2, 20) : $urandom_range(0, 6);
                end
            endcase
        end
    end

    // Sender state. The sender works in bursts of random length; at the end of
    // a burst it may drop valid for a random gap.
    int unsigned burst_left   = 0;
    int unsigned sent_bytes   = 0;
    int unsigned sent_payload = 0;
    logic        octet_now    = 1'b0;
    logic [7:0]  pay_q [$];
    logic [7:0]  bit_acc;
    int unsigned acc_n;

    // Offers one item and waits until the block has taken it.
    task automatic send_item(input logic [7:0] b, input logic last);
        byte_ch.valid        <= 1'b1;
        byte_ch.payload_byte <= b;
        byte_ch.payload_last <= last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        sent_bytes++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            // Valid is only lowered when a real gap follows, so that it never
            // falls and rises within one step.
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic send_payload();
        foreach (pay_q[i])
        begin
            send_item(pay_q[i], i == pay_q.size() - 1);
        end
        sent_payload++;
    endtask

    // Waits until every expected result has come and the block has fallen
    // quiet; mode writes and the verdict only happen then.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        wait_idle();
        cfg_ch.valid              <= 1'b1;
        cfg_ch.octet_aligned_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        octet_now = m;
    endtask

    // Appends the n low bits of v to the payload, most significant first.
    task automatic put_bits(input logic [31:0] v, input int unsigned n);
        for (int i = int'(n) - 1; i >= 0; i--)
        begin
            bit_acc = {bit_acc[6:0], v[i]};
            acc_n++;
            if (acc_n == 8)
            begin
                pay_q.push_back(bit_acc);
                acc_n = 0;
            end
        end
    endtask

    // Short frames are favoured so that a payload stays a handful of items long.
    function automatic logic [3:0] pick_ft();
        return ($urandom_range(0, 9) < 6) ? 4'd8 : 4'($urandom_range(0, 7));
    endfunction

    // Builds one payload: mode request, n_ent entries of the list, an optional
    // entry with a frame type that carries no speech, and the speech bits of
    // every stored frame. A list of the full table depth keeps F set throughout,
    // and then only the zero padding of the last byte follows the list.
    task automatic build_payload(input logic octet, input int unsigned n_ent,
                                 input int fixed_ft, input logic bad_tail);
        logic [3:0] fts [$];
        logic [3:0] ft;
        logic       f;
        logic       q;
        logic       full;
        full = (n_ent >= TOC_DEPTH_DEF);
        pay_q.delete();
        bit_acc = '0;
        acc_n   = 0;
        put_bits($urandom_range(0, 15), 4);
        if (octet) put_bits($urandom_range(0, 15), 4);
        for (int i = 0; i < n_ent; i++)
        begin
            ft = (fixed_ft >= 0) ? fixed_ft[3:0] : pick_ft();
            f  = (i + 1 < n_ent) || full || bad_tail;
            q  = 1'($urandom_range(0, 1));
            put_bits(32'({f, ft, q}), 6);
            if (octet) put_bits($urandom_range(0, 3), 2);
            fts.push_back(ft);
        end
        if (bad_tail)
        begin
            q = 1'($urandom_range(0, 1));
            put_bits(32'({1'($urandom_range(0, 1)), 4'($urandom_range(9, 15)), q}), 6);
            if (octet) put_bits($urandom_range(0, 3), 2);
        end
        if (!full)
        begin
            foreach (fts[i])
            begin
                repeat (SPEECH_LEN[fts[i]]) put_bits($urandom_range(0, 255), 8);
            end
        end
        if (acc_n != 0) pay_q.push_back(bit_acc << (8 - acc_n));
        acc_n = 0;
    endtask

    initial
    begin
        int unsigned phase_mark;
        int unsigned choice;
        int unsigned keep;
        int unsigned n_ent;
        int unsigned random_goal;

        byte_ch.valid             = 1'b0;
        byte_ch.payload_byte      = '0;
        byte_ch.payload_last      = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.octet_aligned_mode = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, bandwidth-efficient packing first.
        write_mode(1'b0);

        // A single all-ones byte: the header is read but the list is cut short,
        // so only a status result comes back.
        pay_q = '{8'hFF};
        send_payload();

        // Two zero bytes: one frame of type 0 whose data is cut short, leaving
        // six bits that are padded out on the last byte.
        pay_q = '{8'h00, 8'h00};
        send_payload();

        // A complete short frame followed by a surplus byte, which is ignored.
        build_payload(1'b0, 1, 8, 1'b0);
        pay_q.push_back(8'hFF);
        send_payload();

        // An empty list: the first entry already has a frame type with no speech.
        build_payload(1'b0, 0, -1, 1'b1);
        pay_q.push_back(8'h5A);
        send_payload();

        // The table fills up, which ends the list and flags the error.
        build_payload(1'b0, TOC_DEPTH_DEF, 8, 1'b0);
        send_payload();

        // Octet-aligned header: one good frame, then a bad frame type.
        write_mode(1'b1);
        build_payload(1'b1, 1, 8, 1'b1);
        send_payload();

        // Random part: mostly well-formed payloads with random content, some
        // cut short, some with surplus bytes, and a little noise. The packing
        // mode flips every few dozen items.
        write_mode(1'b0);
        phase_mark  = sent_bytes;
        random_goal = sent_bytes + RANDOM_ITEMS;
        while (sent_bytes < random_goal)
        begin
            if (sent_bytes - phase_mark >= PHASE_ITEMS)
            begin
                write_mode(~octet_now);
                phase_mark = sent_bytes;
            end
            choice = $urandom_range(0, 99);
            if (choice < 5)
            begin
                build_payload(octet_now, TOC_DEPTH_DEF, -1, 1'b0);
            end
            else if (choice < 13)
            begin
                pay_q.delete();
                repeat ($urandom_range(1, 5)) pay_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                n_ent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
                build_payload(octet_now, n_ent, -1, $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    keep = $urandom_range(1, pay_q.size());
                    while (pay_q.size() > keep) void'(pay_q.pop_back());
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 3)) pay_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_payload();
        end

        wait_idle();

        $display("Sent %0d payloads (%0d items) in both packing modes under varied stalls.",
                 sent_payload, sent_bytes);
        $display("Compared %0d results against the prediction, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb_amr_rtp_payload_depacketizer passed");
        end
        else
        begin
            $display("tb_amr_rtp_payload_depacketizer failed");
        end
        $finish;
    end

endmodule
